[rtl/core/c6502_pkg.sv]
// c6502_pkg: shared types and constants for the 6502 execute block
// holds operation codes, the decoded item record, the result record and reset values
// no dependencies
package c6502_pkg;

    // operation codes as they arrive on the opcode port
    typedef enum logic [4:0] {
        OP_LDA = 5'd0,  OP_LDX = 5'd1,  OP_LDY = 5'd2,  OP_STA = 5'd3,
        OP_STX = 5'd4,  OP_STY = 5'd5,  OP_TAX = 5'd6,  OP_TAY = 5'd7,
        OP_TXA = 5'd8,  OP_TYA = 5'd9,  OP_TSX = 5'd10, OP_TXS = 5'd11,
        OP_AND = 5'd12, OP_EOR = 5'd13, OP_ORA = 5'd14, OP_BIT = 5'd15,
        OP_ADC = 5'd16, OP_SBC = 5'd17, OP_CMP = 5'd18, OP_CPX = 5'd19,
        OP_CPY = 5'd20, OP_INC = 5'd21, OP_INX = 5'd22, OP_INY = 5'd23,
        OP_DEC = 5'd24, OP_DEX = 5'd25, OP_DEY = 5'd26, OP_ASL = 5'd27,
        OP_LSR = 5'd28, OP_ROL = 5'd29
    } op_t;

    // function of the execute unit
    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_PASS,
        ALU_AND,
        ALU_EOR,
        ALU_ORA,
        ALU_BIT,
        ALU_ADC,
        ALU_SBC,
        ALU_CMP,
        ALU_INC,
        ALU_DEC,
        ALU_ASL,
        ALU_LSR,
        ALU_ROL
    } alu_t;

    // first operand source
    typedef enum logic [2:0] {
        SRC_A,
        SRC_X,
        SRC_Y,
        SRC_S,
        SRC_M
    } src_t;

    // destination of the result
    typedef enum logic [2:0] {
        DST_NONE,
        DST_A,
        DST_X,
        DST_Y,
        DST_S,
        DST_MEM
    } dst_t;

    // classified request handed from front to back
    typedef struct packed {
        alu_t       alu;
        src_t       src;
        dst_t       dst;
        logic       set_nz;
        logic [7:0] operand;
    } dec_t;

    // result record as seen on the output ports
    typedef struct packed {
        logic [7:0] write_data;
        logic       write_enable;
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] flags;
    } res_t;

    localparam int DEC_W = $bits(dec_t);
    localparam int RES_W = $bits(res_t);

    // default depth of the internal queues
    localparam int QUEUE_DEPTH = 2;

    // flag bit positions
    localparam int FLAG_N = 7;
    localparam int FLAG_V = 6;
    localparam int FLAG_Z = 1;
    localparam int FLAG_C = 0;

    // register reset values
    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam logic [7:0] FLAGS_RESET = 8'h24;

endpackage

[rtl/core/c6502_queue.sv]
// c6502_queue: small register queue with push/full and pop/empty sides
// generic over width and depth; used between front and back and at the output
// no dependencies
module c6502_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // status and handshakes
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer wrap and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/c6502_decode.sv]
// c6502_decode: front end, classifies each incoming request for the execute unit
// maps opcode and accumulator mode onto function, source, destination and flag use
// depends on c6502_pkg
module c6502_decode (
    input  logic [4:0]        opcode,
    input  logic [7:0]        operand,
    input  logic              accumulator_mode,
    output c6502_pkg::dec_t   dec
);

    // classification table
    always_comb
    begin
        dec.alu     = c6502_pkg::ALU_NOP;
        dec.src     = c6502_pkg::SRC_M;
        dec.dst     = c6502_pkg::DST_NONE;
        dec.set_nz  = 1'b0;
        dec.operand = operand;
        case (opcode)
            c6502_pkg::OP_LDA:
            begin
                dec.alu = c6502_pkg::ALU_PASS; dec.src = c6502_pkg::SRC_M;
                dec.dst = c6502_pkg::DST_A;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_LDX:
            begin
                dec.alu = c6502_pkg::ALU_PASS; dec.src = c6502_pkg::SRC_M;
                dec.dst = c6502_pkg::DST_X;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_LDY:
            begin
                dec.alu = c6502_pkg::ALU_PASS; dec.src = c6502_pkg::SRC_M;
                dec.dst = c6502_pkg::DST_Y;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_STA:
            begin
                dec.alu = c6502_pkg::ALU_PASS; dec.src = c6502_pkg::SRC_A;
                dec.dst = c6502_pkg::DST_MEM;
            end
            c6502_pkg::OP_STX:
            begin
                dec.alu = c6502_pkg::ALU_PASS; dec.src = c6502_pkg::SRC_X;
                dec.dst = c6502_pkg::DST_MEM;
            end
            c6502_pkg::OP_STY:
            begin
                dec.alu = c6502_pkg::ALU_PASS; dec.src = c6502_pkg::SRC_Y;
                dec.dst = c6502_pkg::DST_MEM;
            end
            c6502_pkg::OP_TAX:
            begin
                dec.alu = c6502_pkg::ALU_PASS; dec.src = c6502_pkg::SRC_A;
                dec.dst = c6502_pkg::DST_X;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_TAY:
            begin
                dec.alu = c6502_pkg::ALU_PASS; dec.src = c6502_pkg::SRC_A;
                dec.dst = c6502_pkg::DST_Y;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_TXA:
            begin
                dec.alu = c6502_pkg::ALU_PASS; dec.src = c6502_pkg::SRC_X;
                dec.dst = c6502_pkg::DST_A;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_TYA:
            begin
                dec.alu = c6502_pkg::ALU_PASS; dec.src = c6502_pkg::SRC_Y;
                dec.dst = c6502_pkg::DST_A;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_TSX:
            begin
                dec.alu = c6502_pkg::ALU_PASS; dec.src = c6502_pkg::SRC_S;
                dec.dst = c6502_pkg::DST_X;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_TXS:
            begin
                dec.alu = c6502_pkg::ALU_PASS; dec.src = c6502_pkg::SRC_X;
                dec.dst = c6502_pkg::DST_S;
            end
            c6502_pkg::OP_AND:
            begin
                dec.alu = c6502_pkg::ALU_AND;  dec.src = c6502_pkg::SRC_A;
                dec.dst = c6502_pkg::DST_A;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_EOR:
            begin
                dec.alu = c6502_pkg::ALU_EOR;  dec.src = c6502_pkg::SRC_A;
                dec.dst = c6502_pkg::DST_A;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_ORA:
            begin
                dec.alu = c6502_pkg::ALU_ORA;  dec.src = c6502_pkg::SRC_A;
                dec.dst = c6502_pkg::DST_A;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_BIT:
            begin
                dec.alu = c6502_pkg::ALU_BIT;  dec.src = c6502_pkg::SRC_A;
            end
            c6502_pkg::OP_ADC:
            begin
                dec.alu = c6502_pkg::ALU_ADC;  dec.src = c6502_pkg::SRC_A;
                dec.dst = c6502_pkg::DST_A;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_SBC:
            begin
                dec.alu = c6502_pkg::ALU_SBC;  dec.src = c6502_pkg::SRC_A;
                dec.dst = c6502_pkg::DST_A;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_CMP:
            begin
                dec.alu = c6502_pkg::ALU_CMP;  dec.src = c6502_pkg::SRC_A;
                dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_CPX:
            begin
                dec.alu = c6502_pkg::ALU_CMP;  dec.src = c6502_pkg::SRC_X;
                dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_CPY:
            begin
                dec.alu = c6502_pkg::ALU_CMP;  dec.src = c6502_pkg::SRC_Y;
                dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_INC:
            begin
                dec.alu = c6502_pkg::ALU_INC;  dec.src = c6502_pkg::SRC_M;
                dec.dst = c6502_pkg::DST_MEM;  dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_INX:
            begin
                dec.alu = c6502_pkg::ALU_INC;  dec.src = c6502_pkg::SRC_X;
                dec.dst = c6502_pkg::DST_X;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_INY:
            begin
                dec.alu = c6502_pkg::ALU_INC;  dec.src = c6502_pkg::SRC_Y;
                dec.dst = c6502_pkg::DST_Y;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_DEC:
            begin
                dec.alu = c6502_pkg::ALU_DEC;  dec.src = c6502_pkg::SRC_M;
                dec.dst = c6502_pkg::DST_MEM;  dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_DEX:
            begin
                dec.alu = c6502_pkg::ALU_DEC;  dec.src = c6502_pkg::SRC_X;
                dec.dst = c6502_pkg::DST_X;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_DEY:
            begin
                dec.alu = c6502_pkg::ALU_DEC;  dec.src = c6502_pkg::SRC_Y;
                dec.dst = c6502_pkg::DST_Y;    dec.set_nz = 1'b1;
            end
            c6502_pkg::OP_ASL, c6502_pkg::OP_LSR, c6502_pkg::OP_ROL:
            begin
                case (opcode)
                    c6502_pkg::OP_ASL: dec.alu = c6502_pkg::ALU_ASL;
                    c6502_pkg::OP_LSR: dec.alu = c6502_pkg::ALU_LSR;
                    default:           dec.alu = c6502_pkg::ALU_ROL;
                endcase
                dec.src    = accumulator_mode ? c6502_pkg::SRC_A : c6502_pkg::SRC_M;
                dec.dst    = accumulator_mode ? c6502_pkg::DST_A : c6502_pkg::DST_MEM;
                dec.set_nz = 1'b1;
            end
            // unused codes change nothing
            default:
            begin
                dec.alu = c6502_pkg::ALU_NOP;
            end
        endcase
    end

endmodule

[rtl/core/c6502_execute.sv]
// c6502_execute: back end, register file, flags and the 8-bit ALU
// takes one classified request a cycle while go is high and produces the full result record
// depends on c6502_pkg
module c6502_execute (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  c6502_pkg::dec_t   dec,
    output c6502_pkg::res_t   res
);

    logic [7:0] acc_reg,   acc_next;
    logic [7:0] x_reg,     x_next;
    logic [7:0] y_reg,     y_next;
    logic [7:0] sp_reg,    sp_next;
    logic [7:0] flags_reg, flags_next;
    logic [7:0] src_val;
    logic [7:0] opb;
    logic       cin;
    logic [8:0] sum;
    logic [7:0] alu_out;

    // source select
    always_comb
    begin
        case (dec.src)
            c6502_pkg::SRC_A: src_val = acc_reg;
            c6502_pkg::SRC_X: src_val = x_reg;
            c6502_pkg::SRC_Y: src_val = y_reg;
            c6502_pkg::SRC_S: src_val = sp_reg;
            default:          src_val = dec.operand;
        endcase
    end

    // shared adder for adc, sbc and compares
    assign opb = (dec.alu == c6502_pkg::ALU_SBC || dec.alu == c6502_pkg::ALU_CMP)
                 ? ~dec.operand : dec.operand;
    assign cin = (dec.alu == c6502_pkg::ALU_CMP) ? 1'b1 : flags_reg[c6502_pkg::FLAG_C];
    assign sum = {1'b0, src_val} + {1'b0, opb} + {8'd0, cin};

    // alu result and flags
    always_comb
    begin
        alu_out    = src_val;
        flags_next = flags_reg;
        case (dec.alu)
            c6502_pkg::ALU_AND: alu_out = src_val & dec.operand;
            c6502_pkg::ALU_EOR: alu_out = src_val ^ dec.operand;
            c6502_pkg::ALU_ORA: alu_out = src_val | dec.operand;
            c6502_pkg::ALU_BIT:
            begin
                alu_out = src_val & dec.operand;
                flags_next[c6502_pkg::FLAG_Z] = (alu_out == 8'd0);
                flags_next[c6502_pkg::FLAG_N] = dec.operand[7];
                flags_next[c6502_pkg::FLAG_V] = dec.operand[6];
            end
            c6502_pkg::ALU_ADC, c6502_pkg::ALU_SBC:
            begin
                alu_out = sum[7:0];
                flags_next[c6502_pkg::FLAG_C] = sum[8];
                flags_next[c6502_pkg::FLAG_V] = ~(src_val[7] ^ opb[7]) & (src_val[7] ^ sum[7]);
            end
            c6502_pkg::ALU_CMP:
            begin
                alu_out = sum[7:0];
                flags_next[c6502_pkg::FLAG_C] = sum[8];
            end
            c6502_pkg::ALU_INC: alu_out = src_val + 8'd1;
            c6502_pkg::ALU_DEC: alu_out = src_val - 8'd1;
            c6502_pkg::ALU_ASL:
            begin
                alu_out = {src_val[6:0], 1'b0};
                flags_next[c6502_pkg::FLAG_C] = src_val[7];
            end
            c6502_pkg::ALU_LSR:
            begin
                alu_out = {1'b0, src_val[7:1]};
                flags_next[c6502_pkg::FLAG_C] = src_val[0];
            end
            c6502_pkg::ALU_ROL:
            begin
                alu_out = {src_val[6:0], flags_reg[c6502_pkg::FLAG_C]};
                flags_next[c6502_pkg::FLAG_C] = src_val[7];
            end
            default: alu_out = src_val;
        endcase
        if (dec.set_nz)
        begin
            flags_next[c6502_pkg::FLAG_Z] = (alu_out == 8'd0);
            flags_next[c6502_pkg::FLAG_N] = alu_out[7];
        end
    end

    // destination write-back
    always_comb
    begin
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        sp_next  = sp_reg;
        case (dec.dst)
            c6502_pkg::DST_A: acc_next = alu_out;
            c6502_pkg::DST_X: x_next   = alu_out;
            c6502_pkg::DST_Y: y_next   = alu_out;
            c6502_pkg::DST_S: sp_next  = alu_out;
            default:          acc_next = acc_reg;
        endcase
    end

    // result record
    always_comb
    begin
        res.write_enable = (dec.dst == c6502_pkg::DST_MEM);
        res.write_data   = res.write_enable ? alu_out : 8'd0;
        res.acc          = acc_next;
        res.x            = x_next;
        res.y            = y_next;
        res.sp           = sp_next;
        res.flags        = flags_next;
    end

    // architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= 8'd0;
            x_reg     <= 8'd0;
            y_reg     <= 8'd0;
            sp_reg    <= c6502_pkg::SP_RESET;
            flags_reg <= c6502_pkg::FLAGS_RESET;
        end
        else if (go)
        begin
            acc_reg   <= acc_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            sp_reg    <= sp_next;
            flags_reg <= flags_next;
        end
    end

endmodule

[rtl/core/cpu6502_alu_register_execute.sv]
// cpu6502_alu_register_execute: 6502 execute stage top level
// decode front, request queue, execute back and result queue
// depends on c6502_pkg, c6502_decode, c6502_queue, c6502_execute
//
// usage
//   input side is a queue: drive opcode, operand and accumulator_mode and raise
//   push; the request is taken at a rising edge with push high and full low
//   output side is a queue: while empty is low the oldest result sits on
//   write_data .. flags_out; raise pop to take it
//   flow: a request is registered in the request queue, the execute unit pushes
//   its result into the result queue as it leaves the request queue, and the
//   result sits on the result ports once registered there, ready to be popped
//   throughput: one request per cycle while a request waits and the result queue
//   has room, set by the ALU and flag update in the execute unit that closes the register loop
//   each queue holds QUEUE_DEPTH entries; when pop stays low the result queue
//   fills, the execute unit stops, the request queue fills and full rises
//   reset: A, X, Y cleared, SP = 0xFD, status = 0x24, both queues emptied
module cpu6502_alu_register_execute #(
    parameter int QUEUE_DEPTH = c6502_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [4:0] opcode,
    input  logic [7:0] operand,
    input  logic       accumulator_mode,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] write_data,
    output logic       write_enable,
    output logic [7:0] acc_out,
    output logic [7:0] x_out,
    output logic [7:0] y_out,
    output logic [7:0] sp_out,
    output logic [7:0] flags_out
);

    c6502_pkg::dec_t dec_in;
    c6502_pkg::dec_t dec_out;
    c6502_pkg::res_t res_in;
    c6502_pkg::res_t res_out;
    logic            req_empty;
    logic            res_full;
    logic            exec_go;

    // front: classify requests
    c6502_decode u_decode (
        .opcode           (opcode),
        .operand          (operand),
        .accumulator_mode (accumulator_mode),
        .dec              (dec_in)
    );

    // queue between front and back
    c6502_queue #(
        .WIDTH (c6502_pkg::DEC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (dec_in),
        .full      (full),
        .pop       (exec_go),
        .pop_data  (dec_out),
        .empty     (req_empty)
    );

    // back: execute when a request waits and the result queue has room
    assign exec_go = !req_empty && !res_full;

    c6502_execute u_execute (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (exec_go),
        .dec   (dec_out),
        .res   (res_in)
    );

    // result queue
    c6502_queue #(
        .WIDTH (c6502_pkg::RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (exec_go),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    // result ports
    assign write_data   = res_out.write_data;
    assign write_enable = res_out.write_enable;
    assign acc_out      = res_out.acc;
    assign x_out        = res_out.x;
    assign y_out        = res_out.y;
    assign sp_out       = res_out.sp;
    assign flags_out    = res_out.flags;

    // unused status bits keep their reset pattern in every result
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (flags_out[5:2] == c6502_pkg::FLAGS_RESET[5:2]))
        else $error("reserved status bits changed");

    // no write-back byte without a write
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !write_enable) |-> (write_data == 8'd0))
        else $error("write data set without write enable");

    // execute never runs into a full result queue or an empty request queue
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |-> (!res_full && !req_empty))
        else $error("execute fired without room or request");

    // while execute is stalled and nothing is popped, the result on the ports holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (!exec_go && !empty && !pop) |=> $stable(acc_out) && $stable(flags_out))
        else $error("result changed while held");

endmodule

[tb/cpu6502_alu_register_execute_check.sv]
// cpu6502_alu_register_execute_check: watches both queue sides of the execute block
// predicts registers, flags and write-back for each request and compares every result
// depends on c6502_pkg
module cpu6502_alu_register_execute_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [4:0] opcode,
    input  logic [7:0] operand,
    input  logic       accumulator_mode,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] write_data,
    input  logic       write_enable,
    input  logic [7:0] acc_out,
    input  logic [7:0] x_out,
    input  logic [7:0] y_out,
    input  logic [7:0] sp_out,
    input  logic [7:0] flags_out,
    output int         failures,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import c6502_pkg::*;

    // predicted architectural state
    logic [7:0] reg_a;
    logic [7:0] reg_x;
    logic [7:0] reg_y;
    logic [7:0] reg_sp;
    logic [7:0] reg_p;

    res_t results_due[$];
    res_t oldest;
    int   fail_count;

    // zero and negative from a result byte
    function automatic void set_nz(input logic [7:0] v);
        reg_p[FLAG_Z] = (v == 8'h00);
        reg_p[FLAG_N] = v[7];
    endfunction

    // compare: carry means register >= operand
    function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
        reg_p[FLAG_C] = (r >= m);
        set_nz(r - m);
    endfunction

    // one instruction: update the predicted state and build the result record
    function automatic res_t execute_instruction(input logic [4:0] op, input logic [7:0] m,
                                                 input logic am);
        logic [8:0] sum;
        logic [7:0] src;
        logic [7:0] shifted;
        logic [7:0] wdata;
        logic       wen;
        logic       carry;
        res_t       r;
        wdata = 8'h00;
        wen   = 1'b0;
        carry = reg_p[FLAG_C];
        case (op)
            OP_LDA: begin reg_a = m; set_nz(reg_a); end
            OP_LDX: begin reg_x = m; set_nz(reg_x); end
            OP_LDY: begin reg_y = m; set_nz(reg_y); end
            OP_STA: begin wdata = reg_a; wen = 1'b1; end
            OP_STX: begin wdata = reg_x; wen = 1'b1; end
            OP_STY: begin wdata = reg_y; wen = 1'b1; end
            OP_TAX: begin reg_x = reg_a; set_nz(reg_x); end
            OP_TAY: begin reg_y = reg_a; set_nz(reg_y); end
            OP_TXA: begin reg_a = reg_x; set_nz(reg_a); end
            OP_TYA: begin reg_a = reg_y; set_nz(reg_a); end
            OP_TSX: begin reg_x = reg_sp; set_nz(reg_x); end
            OP_TXS: reg_sp = reg_x;
            OP_AND: begin reg_a = reg_a & m; set_nz(reg_a); end
            OP_EOR: begin reg_a = reg_a ^ m; set_nz(reg_a); end
            OP_ORA: begin reg_a = reg_a | m; set_nz(reg_a); end
            OP_BIT:
            begin
                reg_p[FLAG_Z] = ((reg_a & m) == 8'h00);
                reg_p[FLAG_N] = m[7];
                reg_p[FLAG_V] = m[6];
            end
            OP_ADC:
            begin
                sum = {1'b0, reg_a} + {1'b0, m} + {8'h00, carry};
                reg_p[FLAG_C] = sum[8];
                reg_p[FLAG_V] = ~(reg_a[7] ^ m[7]) & (reg_a[7] ^ sum[7]);
                reg_a = sum[7:0];
                set_nz(reg_a);
            end
            OP_SBC:
            begin
                // a negative difference wraps into bit 8, which means a borrow
                sum = {1'b0, reg_a} - {1'b0, m} - {8'h00, ~carry};
                reg_p[FLAG_C] = ~sum[8];
                reg_p[FLAG_V] = (reg_a[7] ^ m[7]) & (reg_a[7] ^ sum[7]);
                reg_a = sum[7:0];
                set_nz(reg_a);
            end
            OP_CMP: compare_reg(reg_a, m);
            OP_CPX: compare_reg(reg_x, m);
            OP_CPY: compare_reg(reg_y, m);
            OP_INC: begin wdata = m + 8'd1; wen = 1'b1; set_nz(wdata); end
            OP_INX: begin reg_x = reg_x + 8'd1; set_nz(reg_x); end
            OP_INY: begin reg_y = reg_y + 8'd1; set_nz(reg_y); end
            OP_DEC: begin wdata = m - 8'd1; wen = 1'b1; set_nz(wdata); end
            OP_DEX: begin reg_x = reg_x - 8'd1; set_nz(reg_x); end
            OP_DEY: begin reg_y = reg_y - 8'd1; set_nz(reg_y); end
            OP_ASL, OP_LSR, OP_ROL:
            begin
                src = am ? reg_a : m;
                if (op == OP_LSR)
                begin
                    shifted = {1'b0, src[7:1]};
                    reg_p[FLAG_C] = src[0];
                end
                else
                begin
                    // rotate feeds the old carry in, shift feeds a zero
                    shifted = {src[6:0], (op == OP_ROL) ? carry : 1'b0};
                    reg_p[FLAG_C] = src[7];
                end
                set_nz(shifted);
                if (am)
                    reg_a = shifted;
                else
                begin
                    wdata = shifted;
                    wen   = 1'b1;
                end
            end
            default: ;
        endcase
        r.write_data   = wdata;
        r.write_enable = wen;
        r.acc          = reg_a;
        r.x            = reg_x;
        r.y            = reg_y;
        r.sp           = reg_sp;
        r.flags        = reg_p;
        return r;
    endfunction

    // one field against its prediction
    task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t mismatch %s: expected %02h got %02h", $time, field, want, got);
        end
    endtask

    // results are checked before the request of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_a  = 8'h00;
            reg_x  = 8'h00;
            reg_y  = 8'h00;
            reg_sp = SP_RESET;
            reg_p  = FLAGS_RESET;
            results_due.delete();
            fail_count = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t result with nothing expected", $time);
                end
                else
                begin
                    oldest = results_due.pop_front();
                    check_field("write_data", oldest.write_data, write_data);
                    check_field("write_enable", {7'b0, oldest.write_enable}, {7'b0, write_enable});
                    check_field("acc_out", oldest.acc, acc_out);
                    check_field("x_out", oldest.x, x_out);
                    check_field("y_out", oldest.y, y_out);
                    check_field("sp_out", oldest.sp, sp_out);
                    check_field("flags_out", oldest.flags, flags_out);
                end
            end
            if (push && !full)
                results_due.push_back(execute_instruction(opcode, operand, accumulator_mode));
            failures    <= fail_count;
            outstanding <= results_due.size();
        end
    end

endmodule

[tb/cpu6502_alu_register_execute_test.sv]
// cpu6502_alu_register_execute_test: top of the execute block testbench
// drives requests and result pops with random stalls, takes the verdict from the checker
// depends on c6502_pkg, cpu6502_alu_register_execute, cpu6502_alu_register_execute_check
module cpu6502_alu_register_execute_test;
    timeunit 1ns;
    timeprecision 1ps;
    import c6502_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_REQUESTS = 400;
    localparam int CALM_TAIL       = 60;
    localparam int DRAIN_CYCLES    = 8;

    // codes the block leaves unused
    localparam logic [4:0] OP_UNUSED_LO = 5'd30;
    localparam logic [4:0] OP_UNUSED_HI = 5'd31;

    logic       clk              = 1'b0;
    logic       rst_n            = 1'b0;
    logic       push             = 1'b0;
    logic       pop              = 1'b0;
    logic [4:0] opcode           = 5'd0;
    logic [7:0] operand          = 8'h00;
    logic       accumulator_mode = 1'b0;

    logic       full;
    logic       empty;
    logic [7:0] write_data;
    logic       write_enable;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] sp_out;
    logic [7:0] flags_out;

    int failures;
    int outstanding;
    int cycles    = 0;
    int gap_pct   = 20;
    int stall_pct = 20;
    bit calm      = 1'b0;

    cpu6502_alu_register_execute uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .opcode           (opcode),
        .operand          (operand),
        .accumulator_mode (accumulator_mode),
        .empty            (empty),
        .pop              (pop),
        .write_data       (write_data),
        .write_enable     (write_enable),
        .acc_out          (acc_out),
        .x_out            (x_out),
        .y_out            (y_out),
        .sp_out           (sp_out),
        .flags_out        (flags_out)
    );

    cpu6502_alu_register_execute_check check (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .opcode           (opcode),
        .operand          (operand),
        .accumulator_mode (accumulator_mode),
        .empty            (empty),
        .pop              (pop),
        .write_data       (write_data),
        .write_enable     (write_enable),
        .acc_out          (acc_out),
        .x_out            (x_out),
        .y_out            (y_out),
        .sp_out           (sp_out),
        .flags_out        (flags_out),
        .failures         (failures),
        .outstanding      (outstanding)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // one request, held until taken, then maybe an idle burst
    task automatic send_request(input logic [4:0] op, input logic [7:0] m, input logic am);
        opcode           <= op;
        operand          <= m;
        accumulator_mode <= am;
        push             <= 1'b1;
        do @(posedge clk); while (full);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // hold off requests until every predicted result has come back
    task automatic wait_for_results();
        push <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // result side: pop with random stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 11);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // request side
    initial
    begin
        logic [4:0] op;
        logic [7:0] m;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, stack pointer moves, stores
        send_request(OP_STA, 8'h5A, 1'b1);
        send_request(OP_TSX, 8'hFF, 1'b0);
        send_request(OP_STX, 8'h00, 1'b0);
        send_request(OP_LDX, 8'h00, 1'b1);
        send_request(OP_TXS, 8'h00, 1'b0);
        send_request(OP_LDY, 8'hFF, 1'b0);
        send_request(OP_STY, 8'h00, 1'b0);
        // add and subtract around overflow and carry
        send_request(OP_LDA, 8'h7F, 1'b0);
        send_request(OP_ADC, 8'h01, 1'b0);
        send_request(OP_ADC, 8'hFF, 1'b0);
        send_request(OP_SBC, 8'h80, 1'b0);
        send_request(OP_SBC, 8'hFF, 1'b0);
        // transfers
        send_request(OP_TAX, 8'hFF, 1'b0);
        send_request(OP_TAY, 8'h00, 1'b0);
        send_request(OP_TXA, 8'hFF, 1'b1);
        send_request(OP_TYA, 8'h00, 1'b0);
        // compares
        send_request(OP_CMP, 8'hFF, 1'b0);
        send_request(OP_CPX, 8'h00, 1'b0);
        send_request(OP_CPY, 8'hFF, 1'b0);
        // increments and decrements with wrap
        send_request(OP_INC, 8'hFF, 1'b0);
        send_request(OP_DEC, 8'h00, 1'b1);
        send_request(OP_INX, 8'hAA, 1'b0);
        send_request(OP_INY, 8'h55, 1'b0);
        send_request(OP_DEX, 8'h00, 1'b0);
        send_request(OP_DEY, 8'hFF, 1'b0);
        // logic
        send_request(OP_BIT, 8'hC0, 1'b0);
        send_request(OP_AND, 8'h00, 1'b0);
        send_request(OP_EOR, 8'hFF, 1'b0);
        send_request(OP_ORA, 8'h80, 1'b0);
        // shifts on accumulator and memory
        send_request(OP_ASL, 8'h80, 1'b1);
        send_request(OP_LSR, 8'h01, 1'b0);
        send_request(OP_ROL, 8'h80, 1'b1);
        send_request(OP_ROL, 8'h7F, 1'b0);
        // unused codes
        send_request(OP_UNUSED_LO, 8'hFF, 1'b1);
        send_request(OP_UNUSED_HI, 8'h00, 1'b0);
        wait_for_results();

        // random requests in phases of different idling
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 50 == 0)
            begin
                gap_pct   = 20 * $urandom_range(0, 3);
                stall_pct = 20 * $urandom_range(0, 3);
            end
            calm = (i >= RANDOM_REQUESTS - CALM_TAIL);
            if (i == 150 || i == 300)
                wait_for_results();
            op = 5'($urandom_range(0, 31));
            case ($urandom_range(0, 7))
                0: m = 8'h00;
                1: m = 8'hFF;
                2: m = 8'h80;
                3: m = 8'h7F;
                default: m = 8'($urandom);
            endcase
            send_request(op, m, 1'($urandom_range(0, 1)));
        end

        // drain and settle
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/c6502_pkg.sv
rtl/core/c6502_queue.sv
rtl/core/c6502_decode.sv
rtl/core/c6502_execute.sv
rtl/core/cpu6502_alu_register_execute.sv
tb/cpu6502_alu_register_execute_check.sv
tb/cpu6502_alu_register_execute_test.sv
